// File: design/aavt_pkg.sv
`timescale 1ns / 1ps
package aavt_pkg;

    localparam int NUM_REGS      = 8;
    localparam int TURN          = 5760;
    localparam int QUARTER       = 1440;
    localparam int HALF_TURN_DEG = 180;
    localparam longint unsigned PI_Q30 = 64'd3373259426;
    localparam int SIN_DIV       = 16 * HALF_TURN_DEG;

    // register indexes
    localparam logic [2:0] REG_AXIS_X   = 3'd0;
    localparam logic [2:0] REG_AXIS_Y   = 3'd1;
    localparam logic [2:0] REG_AXIS_Z   = 3'd2;
    localparam logic [2:0] REG_ANGLE    = 3'd3;
    localparam logic [2:0] REG_SCALE    = 3'd4;
    localparam logic [2:0] REG_OFFSET_X = 3'd5;
    localparam logic [2:0] REG_OFFSET_Y = 3'd6;
    localparam logic [2:0] REG_OFFSET_Z = 3'd7;

    localparam int MW = 34;

    typedef logic signed [MW-1:0] coef_t;
    typedef coef_t [2:0][2:0] mat_t;
    typedef logic [14:0] sin_rom_t [0:QUARTER];

    function automatic longint unsigned mul30(longint unsigned a, longint unsigned b);
        return (a * b) >> 30;
    endfunction

    // Q1.14 sine of r sixteenths of a degree, first quadrant, from a Q30 series
    function automatic sin_rom_t build_sin_rom();
        sin_rom_t rom;
        longint unsigned x;
        longint unsigned term;
        longint sum;
        for (int r = 0; r <= QUARTER; r++) begin
            x = (64'(r) * PI_Q30 + 64'(QUARTER)) / SIN_DIV;
            term = x;
            sum = longint'(x);
            term = mul30(mul30(term, x), x) / 64'd6;   sum = sum - longint'(term);
            term = mul30(mul30(term, x), x) / 64'd20;  sum = sum + longint'(term);
            term = mul30(mul30(term, x), x) / 64'd42;  sum = sum - longint'(term);
            term = mul30(mul30(term, x), x) / 64'd72;  sum = sum + longint'(term);
            term = mul30(mul30(term, x), x) / 64'd110; sum = sum - longint'(term);
            term = mul30(mul30(term, x), x) / 64'd156; sum = sum + longint'(term);
            term = mul30(mul30(term, x), x) / 64'd210; sum = sum - longint'(term);
            if (sum < 0) begin
                sum = 0;
            end
            rom[r] = 15'((sum + 32768) >>> 16);
        end
        return rom;
    endfunction

endpackage

// File: design/aavt_matrix.sv
`timescale 1ns / 1ps
module aavt_matrix import aavt_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               restart,
    input  logic signed [15:0] axis_x,
    input  logic signed [15:0] axis_y,
    input  logic signed [15:0] axis_z,
    input  logic signed [13:0] angle,
    output mat_t               mat,
    output logic               busy
);

    localparam sin_rom_t SIN_ROM = build_sin_rom();

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ANG  = 3'd1;
    localparam logic [2:0] S_RD0  = 3'd2;
    localparam logic [2:0] S_RD1  = 3'd3;
    localparam logic [2:0] S_SC   = 3'd4;
    localparam logic [2:0] S_PAIR = 3'd5;
    localparam logic [2:0] S_OMC  = 3'd6;
    localparam logic [2:0] S_SUM  = 3'd7;

    logic [2:0] state_reg, state_next;

    logic [1:0]         q_reg, q_next;
    logic [10:0]        r_reg, r_next;
    logic [14:0]        rom_q_reg;
    logic [14:0]        sp_reg;
    logic signed [15:0] s_reg, s_next;
    logic signed [15:0] c_reg, c_next;
    logic signed [16:0] omc_reg;
    logic signed [31:0] pp_reg [6];
    logic signed [31:0] as_reg [3];
    logic signed [48:0] po_reg [6];
    mat_t               mat_reg, mat_next;

    logic signed [14:0] a_w;
    logic signed [14:0] a_red;
    logic signed [15:0] sp_s, cp_s;
    logic signed [35:0] rk [6];
    logic signed [49:0] rt [6];
    logic signed [35:0] cc;
    logic signed [35:0] ax_s, ay_s, az_s;

    // reduce the angle to one turn, then to quadrant and offset
    always_comb begin
        a_w = 15'(angle);
        if (a_w < -15'sd5760) begin
            a_red = a_w + 15'sd11520;
        end else if (a_w < 15'sd0) begin
            a_red = a_w + 15'sd5760;
        end else if (a_w >= 15'sd5760) begin
            a_red = a_w - 15'sd5760;
        end else begin
            a_red = a_w;
        end
        if (a_red >= 15'sd4320) begin
            q_next = 2'd3;
            r_next = 11'(a_red - 15'sd4320);
        end else if (a_red >= 15'sd2880) begin
            q_next = 2'd2;
            r_next = 11'(a_red - 15'sd2880);
        end else if (a_red >= 15'sd1440) begin
            q_next = 2'd1;
            r_next = 11'(a_red - 15'sd1440);
        end else begin
            q_next = 2'd0;
            r_next = 11'(a_red);
        end
    end

    always_comb begin
        sp_s = $signed({1'b0, sp_reg});
        cp_s = $signed({1'b0, rom_q_reg});
        unique case (q_reg)
            2'd0: begin s_next = sp_s;  c_next = cp_s;  end
            2'd1: begin s_next = cp_s;  c_next = -sp_s; end
            2'd2: begin s_next = -sp_s; c_next = -cp_s; end
            default: begin s_next = -cp_s; c_next = sp_s; end
        endcase
    end

    // pair order: xx, yy, zz, xy, xz, yz
    always_comb begin
        for (int k = 0; k < 6; k++) begin
            rt[k] = 50'(po_reg[k]) + 50'sd8192;
            rk[k] = $signed(rt[k][49:14]);
        end
        cc   = $signed({{6{c_reg[15]}}, c_reg, 14'b0});
        ax_s = 36'(as_reg[0]);
        ay_s = 36'(as_reg[1]);
        az_s = 36'(as_reg[2]);
        mat_next[0][0] = MW'(cc + rk[0]);
        mat_next[0][1] = MW'(rk[3] - az_s);
        mat_next[0][2] = MW'(rk[4] + ay_s);
        mat_next[1][0] = MW'(rk[3] + az_s);
        mat_next[1][1] = MW'(cc + rk[1]);
        mat_next[1][2] = MW'(rk[5] - ax_s);
        mat_next[2][0] = MW'(rk[4] - ay_s);
        mat_next[2][1] = MW'(rk[5] + ax_s);
        mat_next[2][2] = MW'(cc + rk[2]);
    end

    always_comb begin
        if (restart) begin
            state_next = S_ANG;
        end else begin
            unique case (state_reg)
                S_IDLE:  state_next = S_IDLE;
                S_ANG:   state_next = S_RD0;
                S_RD0:   state_next = S_RD1;
                S_RD1:   state_next = S_SC;
                S_SC:    state_next = S_PAIR;
                S_PAIR:  state_next = S_OMC;
                S_OMC:   state_next = S_SUM;
                default: state_next = S_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_ANG;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_ANG: begin
                q_reg <= q_next;
                r_reg <= r_next;
            end
            S_RD0: begin
                rom_q_reg <= SIN_ROM[r_reg];
            end
            S_RD1: begin
                sp_reg    <= rom_q_reg;
                rom_q_reg <= SIN_ROM[11'(QUARTER) - r_reg];
            end
            S_SC: begin
                s_reg <= s_next;
                c_reg <= c_next;
            end
            S_PAIR: begin
                omc_reg   <= 17'sd16384 - 17'(c_reg);
                pp_reg[0] <= 32'(axis_x) * 32'(axis_x);
                pp_reg[1] <= 32'(axis_y) * 32'(axis_y);
                pp_reg[2] <= 32'(axis_z) * 32'(axis_z);
                pp_reg[3] <= 32'(axis_x) * 32'(axis_y);
                pp_reg[4] <= 32'(axis_x) * 32'(axis_z);
                pp_reg[5] <= 32'(axis_y) * 32'(axis_z);
                as_reg[0] <= 32'(axis_x) * 32'(s_reg);
                as_reg[1] <= 32'(axis_y) * 32'(s_reg);
                as_reg[2] <= 32'(axis_z) * 32'(s_reg);
            end
            S_OMC: begin
                for (int k = 0; k < 6; k++) begin
                    po_reg[k] <= 49'(pp_reg[k]) * 49'(omc_reg);
                end
            end
            S_SUM: begin
                mat_reg <= mat_next;
            end
            default: begin
            end
        endcase
    end

    assign mat  = mat_reg;
    assign busy = (state_reg != S_IDLE);

    a_restart_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        restart |=> busy)
        else $error("matrix not rebuilding after register write");

    a_sum_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SUM && !restart) |=> (state_reg == S_IDLE))
        else $error("matrix sequencer did not finish");

endmodule

// File: design/aavt_pipe.sv
`timescale 1ns / 1ps
module aavt_pipe import aavt_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [31:0] scale,
    input  logic signed [31:0] offset_x,
    input  logic signed [31:0] offset_y,
    input  logic signed [31:0] offset_z,
    input  mat_t               mat,
    input  logic               busy,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_z
);

    localparam int NSTG = 6;

    logic [NSTG-1:0] v_reg;
    logic            adv;
    logic            accept;

    logic signed [63:0] p_reg  [3];
    logic signed [48:0] t_reg  [3];
    logic signed [58:0] hi_reg [3][3];
    logic signed [58:0] lo_reg [3][3];
    logic signed [60:0] hs_reg [3];
    logic signed [60:0] ls_reg [3];
    logic signed [57:0] r_reg  [3];
    logic signed [31:0] o_reg  [3];

    logic signed [31:0] pos [3];
    logic signed [31:0] off [3];
    logic signed [63:0] pr  [3];
    logic signed [47:0] ps  [3];
    logic signed [24:0] th  [3];
    logic signed [24:0] tl  [3];
    logic signed [85:0] tot [3];
    logic signed [31:0] sat [3];

    // whole pipe holds while the output word waits
    assign adv     = !v_reg[NSTG-1] || m_ready;
    assign s_ready = adv && !busy;
    assign accept  = s_valid && s_ready;

    always_comb begin
        pos[0] = pos_x;    pos[1] = pos_y;    pos[2] = pos_z;
        off[0] = offset_x; off[1] = offset_y; off[2] = offset_z;
        for (int i = 0; i < 3; i++) begin
            pr[i]  = p_reg[i] + 64'sd32768;
            ps[i]  = pr[i][63:16];
            th[i]  = t_reg[i][48:24];
            tl[i]  = $signed({1'b0, t_reg[i][23:0]});
            tot[i] = (86'(hs_reg[i]) <<< 24) + 86'(ls_reg[i]) + 86'sd134217728;
            if (r_reg[i] > 58'sd2147483647) begin
                sat[i] = 32'sh7fffffff;
            end else if (r_reg[i] < -58'sd2147483648) begin
                sat[i] = 32'sh80000000;
            end else begin
                sat[i] = r_reg[i][31:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[NSTG-2:0], accept};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                p_reg[i] <= 64'(pos[i]) * 64'(scale);
                t_reg[i] <= 49'(ps[i]) - 49'(off[i]);
                for (int j = 0; j < 3; j++) begin
                    hi_reg[i][j] <= 59'(mat[i][j]) * 59'(th[j]);
                    lo_reg[i][j] <= 59'(mat[i][j]) * 59'(tl[j]);
                end
                hs_reg[i] <= 61'(hi_reg[i][0]) + 61'(hi_reg[i][1]) + 61'(hi_reg[i][2]);
                ls_reg[i] <= 61'(lo_reg[i][0]) + 61'(lo_reg[i][1]) + 61'(lo_reg[i][2]);
                r_reg[i]  <= tot[i][85:28];
                o_reg[i]  <= sat[i];
            end
        end
    end

    assign m_valid = v_reg[NSTG-1];
    assign out_x   = o_reg[0];
    assign out_y   = o_reg[1];
    assign out_z   = o_reg[2];

    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> v_reg[0])
        else $error("accepted word missing from first stage");

    a_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(v_reg))
        else $error("pipe moved during output stall");

endmodule

// File: design/axis_angle_vertex_transform.sv
`timescale 1ns / 1ps
// Channel   Ports                                  Word
// input     s_valid s_ready s_pos_x/y/z            one vertex, Q16.16
// result    m_valid m_ready m_out_x/y/z            rotated vertex, Q16.16 sat
// config    psel penable pwrite paddr pwdata ...   eight registers at 4*i
//
// One vertex per cycle while s_ready is high; each passes through the scale, offset,
// split product, row sums, rounding and saturation stages.
// A stalled result word holds the whole pipe; nothing is dropped.
// After reset and after any register write the rotation matrix is rebuilt
// by a sequencer with a sine table; s_ready is low meanwhile.
// Reset is synchronous, active low.
module axis_angle_vertex_transform import aavt_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_pos_x,
    input  logic signed [31:0] s_pos_y,
    input  logic signed [31:0] s_pos_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_out_x,
    output logic signed [31:0] m_out_y,
    output logic signed [31:0] m_out_z,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic signed [15:0] axis_x_reg, axis_y_reg, axis_z_reg;
    logic signed [13:0] angle_reg;
    logic signed [31:0] scale_reg;
    logic signed [31:0] offset_x_reg, offset_y_reg, offset_z_reg;

    logic       wr;
    logic [2:0] idx;
    mat_t       mat;
    logic       busy;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;
    assign idx    = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            axis_x_reg   <= '0;
            axis_y_reg   <= '0;
            axis_z_reg   <= 16'sd16384;
            angle_reg    <= '0;
            scale_reg    <= 32'sd65536;
            offset_x_reg <= '0;
            offset_y_reg <= '0;
            offset_z_reg <= '0;
        end else if (wr) begin
            unique case (idx)
                REG_AXIS_X:   axis_x_reg   <= pwdata[15:0];
                REG_AXIS_Y:   axis_y_reg   <= pwdata[15:0];
                REG_AXIS_Z:   axis_z_reg   <= pwdata[15:0];
                REG_ANGLE:    angle_reg    <= pwdata[13:0];
                REG_SCALE:    scale_reg    <= pwdata;
                REG_OFFSET_X: offset_x_reg <= pwdata;
                REG_OFFSET_Y: offset_y_reg <= pwdata;
                default:      offset_z_reg <= pwdata;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_AXIS_X:   prdata = {16'b0, axis_x_reg};
            REG_AXIS_Y:   prdata = {16'b0, axis_y_reg};
            REG_AXIS_Z:   prdata = {16'b0, axis_z_reg};
            REG_ANGLE:    prdata = {18'b0, angle_reg};
            REG_SCALE:    prdata = scale_reg;
            REG_OFFSET_X: prdata = offset_x_reg;
            REG_OFFSET_Y: prdata = offset_y_reg;
            default:      prdata = offset_z_reg;
        endcase
    end

    aavt_matrix u_matrix (
        .aclk    (aclk),
        .aresetn (aresetn),
        .restart (wr),
        .axis_x  (axis_x_reg),
        .axis_y  (axis_y_reg),
        .axis_z  (axis_z_reg),
        .angle   (angle_reg),
        .mat     (mat),
        .busy    (busy)
    );

    aavt_pipe u_pipe (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .pos_x    (s_pos_x),
        .pos_y    (s_pos_y),
        .pos_z    (s_pos_z),
        .scale    (scale_reg),
        .offset_x (offset_x_reg),
        .offset_y (offset_y_reg),
        .offset_z (offset_z_reg),
        .mat      (mat),
        .busy     (busy),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .out_x    (m_out_x),
        .out_y    (m_out_y),
        .out_z    (m_out_z)
    );

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import aavt_pkg::*;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } vertex_t;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        bit                 known;
        logic signed [31:0] ex;
        logic signed [31:0] ey;
        logic signed [31:0] ez;
    } stim_row_t;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int REG_W [NUM_REGS] = '{16, 16, 16, 14, 32, 32, 32, 32};

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic signed [31:0] s_pos_x;
    logic signed [31:0] s_pos_y;
    logic signed [31:0] s_pos_z;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_out_x;
    logic signed [31:0] m_out_y;
    logic signed [31:0] m_out_z;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [4:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    vertex_t     pending_vertices[$];
    logic [31:0] shadow_reg [NUM_REGS];
    int          mismatches;
    int          cycle_count;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_left;
    bit          hold_req;

    axis_angle_vertex_transform u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_pos_x (s_pos_x),
        .s_pos_y (s_pos_y),
        .s_pos_z (s_pos_z),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_out_x (m_out_x),
        .m_out_y (m_out_y),
        .m_out_z (m_out_z),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic longint sext_reg(int idx);
        logic [63:0] v;
        v = 64'(shadow_reg[idx]);
        if (v[REG_W[idx]-1])
            v = v | ~((64'd1 << REG_W[idx]) - 64'd1);
        return longint'(v);
    endfunction

    // Q1.14 sine of r sixteenths of a degree, r within the first quadrant
    function automatic longint quadrant_sine(longint r);
        longint unsigned x;
        longint unsigned term;
        longint          sum;
        x = (longint'(r) * PI_Q30 + 64'(QUARTER)) / 64'(16 * HALF_TURN_DEG);
        term = x;
        sum = longint'(x);
        for (int k = 1; k <= 7; k++) begin
            term = (term * x) >> 30;
            term = ((term * x) >> 30) / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        return (sum + 32768) >>> 16;
    endfunction

    function automatic longint round_q14(longint p);
        return (p + 8192) >>> 14;
    endfunction

    function automatic vertex_t rotate_vertex(vertex_t pos);
        longint              axv [3];
        longint              m [3][3];
        longint              t [3];
        longint              ang, sp, cp, s, c, omc, cc, p, sgn;
        int                  q;
        logic signed [127:0] acc, wm, wt;
        longint              comp [3];
        vertex_t             res;
        for (int i = 0; i < 3; i++)
            axv[i] = sext_reg(i);
        ang = sext_reg(REG_ANGLE) % TURN;
        if (ang < 0)
            ang += TURN;
        q = int'(ang / QUARTER);
        ang = ang % QUARTER;
        sp = quadrant_sine(ang);
        cp = quadrant_sine(QUARTER - ang);
        case (q)
            0: begin s = sp;  c = cp;  end
            1: begin s = cp;  c = -sp; end
            2: begin s = -sp; c = -cp; end
            default: begin s = -cp; c = sp; end
        endcase
        omc = 16384 - c;
        cc = c * 16384;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                m[i][j] = round_q14(axv[i] * axv[j] * omc);
                if (i == j) begin
                    m[i][j] += cc;
                end else begin
                    // cross-product term: k is the remaining axis, sign by cyclic order
                    sgn = ((j - i + 3) % 3 == 1) ? -1 : 1;
                    m[i][j] += sgn * axv[3 - i - j] * s;
                end
            end
        end
        t[0] = longint'(pos.x);
        t[1] = longint'(pos.y);
        t[2] = longint'(pos.z);
        for (int i = 0; i < 3; i++) begin
            p = t[i] * sext_reg(REG_SCALE);
            t[i] = ((p + 32768) >>> 16) - sext_reg(REG_OFFSET_X + i);
        end
        for (int i = 0; i < 3; i++) begin
            acc = 0;
            for (int j = 0; j < 3; j++) begin
                wm = m[i][j];
                wt = t[j];
                acc += wm * wt;
            end
            acc = (acc + (128'sd1 <<< 27)) >>> 28;
            if (acc > 128'sd2147483647)
                acc = 128'sd2147483647;
            if (acc < -128'sd2147483648)
                acc = -128'sd2147483648;
            comp[i] = longint'(acc);
        end
        res.x = comp[0][31:0];
        res.y = comp[1][31:0];
        res.z = comp[2][31:0];
        return res;
    endfunction

    // receiver: random stalls, or a long hold-off on request
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready = 1'b0;
        end else if (hold_req && hold_left == 0) begin
            hold_left = 300;
            hold_req = 1'b0;
            m_ready = 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready = 1'b0;
        end else begin
            m_ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        vertex_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_vertices.size() == 0) begin
                $error("unexpected result word x=%0d y=%0d z=%0d", m_out_x, m_out_y, m_out_z);
                mismatches++;
            end else begin
                want = pending_vertices.pop_front();
                if (m_out_x !== want.x) begin
                    $error("out_x expected %0d actual %0d", want.x, m_out_x);
                    mismatches++;
                end
                if (m_out_y !== want.y) begin
                    $error("out_y expected %0d actual %0d", want.y, m_out_y);
                    mismatches++;
                end
                if (m_out_z !== want.z) begin
                    $error("out_z expected %0d actual %0d", want.z, m_out_z);
                    mismatches++;
                end
            end
        end
    end

    task automatic settle_pipe();
        wait (pending_vertices.size() == 0);
        repeat (12) @(negedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        @(negedge aclk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        shadow_reg[idx] = value & 32'((64'd1 << REG_W[idx]) - 64'd1);
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic load_setup(logic [31:0] vals [NUM_REGS]);
        settle_pipe();
        for (int i = 0; i < NUM_REGS; i++)
            write_reg(3'(i), vals[i]);
    endtask

    // offer one word, hold until accepted, queue its expectation
    task automatic send_vertex(vertex_t pos, bit known, vertex_t want);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_pos_x = pos.x;
        s_pos_y = pos.y;
        s_pos_z = pos.z;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        pending_vertices.push_back(known ? want : rotate_vertex(pos));
        @(negedge aclk);
    endtask

    task automatic stop_sending();
        s_valid = 1'b0;
    endtask

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(3))
            0: return 32'($urandom_range(2000000)) - 32'd1000000;
            1: return 32'($urandom_range(200)) << 16;
            default: return $urandom();
        endcase
    endfunction

    function automatic vertex_t random_vertex();
        vertex_t v;
        v.x = pick_coord();
        v.y = pick_coord();
        v.z = pick_coord();
        return v;
    endfunction

    function automatic stim_row_t row_of(int x, int y, int z, bit known, int ex, int ey, int ez);
        stim_row_t r;
        r.x = x; r.y = y; r.z = z;
        r.known = known;
        r.ex = ex; r.ey = ey; r.ez = ez;
        return r;
    endfunction

    initial begin
        stim_row_t   identity_rows [$];
        stim_row_t   rows [$];
        logic [31:0] setup [NUM_REGS];
        vertex_t     v, w;
        int          phase;
        mismatches = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left = 0;
        hold_req = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_pos_x = '0;
        s_pos_y = '0;
        s_pos_z = '0;
        m_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        shadow_reg = '{32'd0, 32'd0, 32'd16384, 32'd0, 32'd65536, 32'd0, 32'd0, 32'd0};
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        // reset setup is the identity: each word passes through unchanged
        identity_rows.push_back(row_of(0, 0, 0, 1, 0, 0, 0));
        identity_rows.push_back(row_of(32'h7fffffff, 32'h80000000, 1, 1,
                                       32'h7fffffff, 32'h80000000, 1));
        identity_rows.push_back(row_of(32'h80000000, 32'h7fffffff, -1, 1,
                                       32'h80000000, 32'h7fffffff, -1));
        identity_rows.push_back(row_of(32'h00010000, -32'sh00020000, 32'h55555555, 1,
                                       32'h00010000, -32'sh00020000, 32'h55555555));
        foreach (identity_rows[i]) begin
            v.x = identity_rows[i].x; v.y = identity_rows[i].y; v.z = identity_rows[i].z;
            w.x = identity_rows[i].ex; w.y = identity_rows[i].ey; w.z = identity_rows[i].ez;
            send_vertex(v, 1'b1, w);
        end
        stop_sending();

        rows.push_back(row_of(32'h00010000, 32'h00020000, 32'h00030000, 0, 0, 0, 0));
        rows.push_back(row_of(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, 0, 0));
        rows.push_back(row_of(32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0, 0));
        rows.push_back(row_of(-32'sh00012345, 32'h0abcdef0, 0, 0, 0, 0, 0));
        // quarter turn about z, half turn about x, beyond one turn, negative angle,
        // non-unit axis with negative scale and offsets driving saturation
        for (int k = 0; k < 5; k++) begin
            case (k)
                0: setup = '{32'd0, 32'd0, 32'd16384, 32'd1440, 32'd65536, 0, 0, 0};
                1: setup = '{32'd16384, 32'd0, 32'd0, 32'd2880, 32'd131072,
                             32'h00010000, 0, 32'hffff0000};
                2: setup = '{32'd0, 32'hffffc000, 32'd0, 32'd8191, 32'h7fffffff,
                             32'h7fffffff, 32'h80000000, 32'h12345678};
                3: setup = '{32'hffffc000, 32'hffffc000, 32'h7fff, 32'h2000,
                             32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000};
                default: setup = '{32'hffff9c00, 32'h2000, 32'h4000, 32'hffffe900,
                                   32'hfffe0000, 0, 32'h00500000, 0};
            endcase
            load_setup(setup);
            foreach (rows[i]) begin
                v.x = rows[i].x; v.y = rows[i].y; v.z = rows[i].z;
                send_vertex(v, 1'b0, v);
            end
            stop_sending();
        end

        for (phase = 0; phase < 10; phase++) begin
            case (phase)
                0: setup = '{32'd0, 32'd0, 32'd16384, 32'd5760, 32'd65536, 0, 0, 0};
                1: setup = '{32'd16384, 32'd16384, 32'd16384, 32'hffffe000,
                             32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff};
                2: setup = '{32'hc000, 32'hc000, 32'hc000, 32'h1fff,
                             32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000};
                default: begin
                    for (int i = 0; i < 3; i++)
                        setup[i] = ($urandom_range(1)) ? 32'($urandom_range(32768)) - 32'd16384
                                                       : $urandom();
                    setup[REG_ANGLE] = $urandom();
                    setup[REG_SCALE] = ($urandom_range(1)) ? $urandom()
                                       : 32'($urandom_range(300000));
                    for (int i = 0; i < 3; i++)
                        setup[REG_OFFSET_X + i] = ($urandom_range(1)) ? $urandom()
                                                  : 32'($urandom_range(2000000)) - 32'd1000000;
                end
            endcase
            load_setup(setup);
            if (phase < 3) begin
                send_idle_pct = 20; recv_idle_pct = 81;
            end else if (phase < 6) begin
                send_idle_pct = 81; recv_idle_pct = 20;
            end else begin
                send_idle_pct = 0; recv_idle_pct = 0;
            end
            for (int n = 0; n < 70; n++) begin
                if (phase == 7 && n == 10)
                    hold_req = 1'b1;
                if (phase == 8 && n == 35) begin
                    stop_sending();
                    wait (pending_vertices.size() == 0);
                    @(negedge aclk);
                end
                v = random_vertex();
                send_vertex(v, 1'b0, v);
            end
            stop_sending();
        end

        wait (pending_vertices.size() == 0);
        repeat (20) @(posedge aclk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: filelist.f
design/aavt_pkg.sv
design/aavt_matrix.sv
design/aavt_pipe.sv
design/axis_angle_vertex_transform.sv
verif/testbench.sv
